>>> rtl/tlgs_pkg.sv
// Shared types and constants for the toroidal life grid stepper.
// Holds the command codes, the sequencer state type and field widths.
// No dependencies; imported by every module of the block.
package tlgs_pkg;

  // Default grid maximums, used as top level parameter defaults
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  // Fixed field widths of the stream items and size registers
  localparam int CMD_W      = 2;
  localparam int COORD_W    = 6;
  localparam int SIZE_REG_W = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Size register value after reset
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 7'd64;

  // Configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Neighbor counts of rule B3/S23
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Command codes carried in the input item
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,  // sweep the plane to dead after reset
    ST_IDLE,   // wait for a transaction
    ST_ACC,    // row data back: modify and write, or pick the read bit
    ST_PRE0,   // step: fetch last row in use
    ST_PRE1,   // step: fetch row zero
    ST_PRE2,   // step: fetch row one
    ST_ROW,    // step: update one row per cycle in place
    ST_DONE    // step: post the result
  } state_t;

endpackage

>>> rtl/tlgs_row_update.sv
// Next-generation logic for one full grid row under rule B3/S23.
// Wraps columns at the width in use and carries columns beyond it unchanged.
// Depends on tlgs_pkg for the rule counts.
module tlgs_row_update
  import tlgs_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int CW  = $clog2(MAX_COLS + 1),
  localparam int CIW = $clog2(MAX_COLS)
) (
  input  logic [MAX_COLS-1:0] prev_row,
  input  logic [MAX_COLS-1:0] cur_row,
  input  logic [MAX_COLS-1:0] next_row,
  input  logic [CW-1:0]       width,
  output logic [MAX_COLS-1:0] new_row
);

  logic [CIW-1:0] last_col;
  logic           prev_hi;
  logic           cur_hi;
  logic           next_hi;

  // Pick the wrapped-in column at the right edge once for all lanes
  assign last_col = CIW'(width - CW'(1));
  assign prev_hi  = prev_row[last_col];
  assign cur_hi   = cur_row[last_col];
  assign next_hi  = next_row[last_col];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    logic       lp, lc, ln;
    logic       rp, rc, rn;
    logic       rb_p, rb_c, rb_n;
    logic [3:0] nbr;
    logic       in_use;
    logic       at_last;

    assign in_use  = CW'(c) < width;
    assign at_last = CW'(c) == width - CW'(1);

    // Left neighbors wrap to the last column in use
    if (c == 0) begin : g_left_wrap
      assign lp = prev_hi;
      assign lc = cur_hi;
      assign ln = next_hi;
    end else begin : g_left
      assign lp = prev_row[c-1];
      assign lc = cur_row[c-1];
      assign ln = next_row[c-1];
    end

    // Right neighbors wrap to column zero at the last column in use
    if (c == MAX_COLS - 1) begin : g_right_edge
      assign rb_p = prev_row[0];
      assign rb_c = cur_row[0];
      assign rb_n = next_row[0];
    end else begin : g_right
      assign rb_p = prev_row[c+1];
      assign rb_c = cur_row[c+1];
      assign rb_n = next_row[c+1];
    end
    assign rp = at_last ? prev_row[0] : rb_p;
    assign rc = at_last ? cur_row[0]  : rb_c;
    assign rn = at_last ? next_row[0] : rb_n;

    // Count the eight neighbors
    assign nbr = 4'(lp) + 4'(prev_row[c]) + 4'(rp)
               + 4'(lc) + 4'(rc)
               + 4'(ln) + 4'(next_row[c]) + 4'(rn);

    // Apply the rule inside the size in use, carry the cell outside it
    assign new_row[c] = in_use
                      ? ((nbr == BIRTH_COUNT) || (cur_row[c] && (nbr == SURVIVE_COUNT)))
                      : cur_row[c];
  end

endmodule

>>> rtl/toroidal_life_grid_stepper.sv
// Toroidal Game of Life grid stepper (rule B3/S23), top level.
// Holds the cell plane as one row-wide synchronous memory and the sequencer.
// Depends on tlgs_pkg and tlgs_row_update.
//
// Usage
//   Input stream in_*: one transaction per command (load a cell, advance one
//   generation, read a cell). Result stream out_*: exactly one transaction per
//   command, in order. Size registers are written on cfg_* while the block is
//   idle; values of 0 act as 1 and values above the maximum act as the maximum.
// Memory access
//   The plane is stored one grid row per memory word, so a cell access is a
//   read-modify-write of its row. For load, read and unused commands the row
//   is fetched on the accepting edge and written back or sampled in ST_ACC,
//   which holds while the output register is full. A step walks the rows in
//   use in place, one row per cycle through the memory, after the fetch states
//   ST_PRE0 to ST_PRE2; ST_DONE then posts the result.
// Reset
//   rst_n is synchronous. Afterwards a clearing pass writes MAX_ROWS rows to
//   dead, one per cycle, with in_tready low; configuration writes are taken.
// Stalls
//   A finished result sits in the output register; the next command is
//   accepted meanwhile and its result waits until out_tready frees the slot.
module toroidal_life_grid_stepper
  import tlgs_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [SIZE_REG_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cmd[1:0], col[7:2], row[13:8], cell_in[14]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // cell_out[0], addr_error[1], done_cmd[3:2]
);

  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int CH  = $clog2(MAX_ROWS + 1);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RAW = $clog2(MAX_ROWS);

  // Sequencer and size registers
  state_t                state_r, state_nxt;
  logic [SIZE_REG_W-1:0] grid_width_r;
  logic [SIZE_REG_W-1:0] grid_height_r;
  logic [RAW-1:0]        clr_r;
  logic [RAW-1:0]        row_r;

  // Command held while it is served
  cmd_t                  item_cmd_r;
  logic [CIW-1:0]        item_col_r;
  logic [RAW-1:0]        item_row_r;
  logic                  item_cell_r;
  logic                  item_err_r;

  // Row windows for the in-place step
  logic [MAX_COLS-1:0]   prev_r;
  logic [MAX_COLS-1:0]   cur_r;
  logic [MAX_COLS-1:0]   row0_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_cell_r;
  logic                  out_err_r;
  cmd_t                  out_cmd_r;

  // Memory
  logic [MAX_COLS-1:0]   plane_mem [MAX_ROWS];
  logic [MAX_COLS-1:0]   mem_rdata_r;
  logic [RAW-1:0]        rd_addr;
  logic                  mem_we;
  logic [RAW-1:0]        wr_addr;
  logic [MAX_COLS-1:0]   wr_data;

  // Decoded input fields
  cmd_t                  in_cmd;
  logic [COORD_W-1:0]    in_col;
  logic [COORD_W-1:0]    in_row;
  logic                  in_cell;
  logic                  in_accept;
  logic                  in_err;

  logic [CW-1:0]         w_use;
  logic [CH-1:0]         h_use;
  logic [RAW-1:0]        h_last;
  logic [RAW:0]          row_p2;
  logic                  out_free;
  logic                  res_load;
  logic                  res_cell;
  logic                  res_err;
  logic [MAX_COLS-1:0]   next_row;
  logic [MAX_COLS-1:0]   new_row;
  logic [MAX_COLS-1:0]   bit_mask;

  assign in_cmd    = cmd_t'(in_tdata[1:0]);
  assign in_col    = in_tdata[7:2];
  assign in_row    = in_tdata[13:8];
  assign in_cell   = in_tdata[14];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Clamp the size registers to 1..maximum
  always_comb begin
    if (grid_width_r == '0) begin
      w_use = CW'(1);
    end else if (int'(grid_width_r) > MAX_COLS) begin
      w_use = CW'(MAX_COLS);
    end else begin
      w_use = CW'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      h_use = CH'(1);
    end else if (int'(grid_height_r) > MAX_ROWS) begin
      h_use = CH'(MAX_ROWS);
    end else begin
      h_use = CH'(grid_height_r);
    end
  end

  assign h_last = RAW'(h_use - CH'(1));
  assign row_p2 = {1'b0, row_r} + (RAW + 1)'(2);

  // Flag loads and reads outside the size in use
  assign in_err = ((in_cmd == CMD_LOAD) || (in_cmd == CMD_READ))
               && ((int'(in_col) >= int'(w_use)) || (int'(in_row) >= int'(h_use)));

  // Row below the one being updated: wraps to saved row zero at the bottom
  assign next_row = (row_r == h_last) ? row0_r : mem_rdata_r;

  tlgs_row_update #(
    .MAX_COLS (MAX_COLS)
  ) u_row_update (
    .prev_row (prev_r),
    .cur_row  (cur_r),
    .next_row (next_row),
    .width    (w_use),
    .new_row  (new_row)
  );

  assign bit_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << item_col_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == RAW'(MAX_ROWS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_cmd == CMD_STEP) ? ST_PRE0 : ST_ACC;
        end
      end
      ST_ACC:  if (out_free) state_nxt = ST_IDLE;
      ST_PRE0: state_nxt = ST_PRE1;
      ST_PRE1: state_nxt = ST_PRE2;
      ST_PRE2: state_nxt = ST_ROW;
      ST_ROW:  if (row_r == h_last) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory addressing, write-back and result
  always_comb begin
    rd_addr  = '0;
    mem_we   = 1'b0;
    wr_addr  = row_r;
    wr_data  = new_row;
    res_load = 1'b0;
    res_cell = 1'b0;
    res_err  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      ST_IDLE: rd_addr = RAW'(in_row);
      ST_ACC: begin
        rd_addr  = item_row_r;
        res_load = out_free;
        res_err  = item_err_r;
        res_cell = !item_err_r && (item_cmd_r == CMD_READ) && mem_rdata_r[item_col_r];
        mem_we   = out_free && !item_err_r && (item_cmd_r == CMD_LOAD);
        wr_addr  = item_row_r;
        wr_data  = item_cell_r ? (mem_rdata_r | bit_mask) : (mem_rdata_r & ~bit_mask);
      end
      ST_PRE0: rd_addr = h_last;
      ST_PRE1: rd_addr = '0;
      ST_PRE2: rd_addr = (h_use == CH'(1)) ? '0 : RAW'(1);
      ST_ROW: begin
        rd_addr = (int'(row_p2) < int'(h_use)) ? RAW'(row_p2) : '0;
        mem_we  = 1'b1;
      end
      ST_DONE: res_load = out_free;
      default: rd_addr = '0;
    endcase
  end

  // Row memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      plane_mem[wr_addr] <= wr_data;
    end
    mem_rdata_r <= plane_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      row_r         <= '0;
      grid_width_r  <= SIZE_RESET;
      grid_height_r <= SIZE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + RAW'(1);
      end
      // Advance the row counter of the step walk
      if (state_r == ST_PRE2) begin
        row_r <= '0;
      end else if (state_r == ST_ROW) begin
        row_r <= row_r + RAW'(1);
      end
      // Take configuration writes
      if (cfg_we && (cfg_addr == REG_GRID_WIDTH)) begin
        grid_width_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_addr == REG_GRID_HEIGHT)) begin
        grid_height_r <= cfg_wdata;
      end
      // Hold the result until the transaction completes
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_cmd_r  <= in_cmd;
      item_col_r  <= CIW'(in_col);
      item_row_r  <= RAW'(in_row);
      item_cell_r <= in_cell;
      item_err_r  <= in_err;
    end
    // Shift the row window during the step
    if (state_r == ST_PRE1) begin
      prev_r <= mem_rdata_r;
    end else if (state_r == ST_PRE2) begin
      cur_r  <= mem_rdata_r;
      row0_r <= mem_rdata_r;
    end else if (state_r == ST_ROW) begin
      prev_r <= cur_r;
      cur_r  <= next_row;
    end
    if (res_load) begin
      out_cell_r <= res_cell;
      out_err_r  <= res_err;
      out_cmd_r  <= item_cmd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_cmd_r, out_err_r, out_cell_r};

  // A step occupies the block: nothing is taken on the following edge
  a_step_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_cmd == CMD_STEP)) |=> !in_tready)
    else $error("input taken right after a step command");

  // The plane is never written while waiting for a command
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("plane write while idle");

  // The step walk stays inside the rows in use
  a_row_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW) |-> (int'(row_r) < int'(h_use)))
    else $error("step row beyond height in use");

  // A posted result echoes the command being served
  a_result_echo: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (out_tvalid && (out_cmd_r == $past(item_cmd_r))))
    else $error("result does not echo its command");

endmodule
